/* rtl/core/handle_free_list_allocator_assert.svh */
// assertion macros for the handle free-list allocator
// expects clk and rst_n in the scope of the module that includes this file
`ifndef HANDLE_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define HANDLE_FREE_LIST_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define HFL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hfl assertion failed");

// next-cycle implication
`define HFL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hfl assertion failed");

`endif

/* rtl/core/hfl_pkg.sv */
// shared types and constants for the handle free-list allocator
// no dependencies
package hfl_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int TAG_BITS      = 32;
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
    localparam int FILL_BITS     = IDX_BITS + 1;

    // tag field is 32 bits wide; only the low TAG_BITS take part
    localparam logic [63:0] TAG_MASK64 = ((64'd1 << (TAG_BITS - 1)) << 1) - 64'd1;
    localparam logic [31:0] TAG_MASK   = TAG_MASK64[31:0];

    localparam logic [1:0] KIND_ALLOC  = 2'd0;
    localparam logic [1:0] KIND_FREE   = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    localparam logic [2:0] STATUS_OK      = 3'd0;
    localparam logic [2:0] STATUS_FULL    = 3'd1;
    localparam logic [2:0] STATUS_RANGE   = 3'd2;
    localparam logic [2:0] STATUS_UNALLOC = 3'd3;
    localparam logic [2:0] STATUS_NULL    = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  handle;
        logic [31:0] object_tag;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  result_handle;
        logic [31:0] result_tag;
    } rsp_t;

endpackage

/* rtl/core/hfl_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
// no dependencies; read data holds while rd_en is low
module hfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/handle_free_list_allocator.sv */
// handle free-list allocator top level
// depends on hfl_pkg, hfl_ram and handle_free_list_allocator_assert.svh
//
//  channel | signals                          | direction | payload
//  --------+----------------------------------+-----------+---------------
//  request | req_valid, req_ready, req_data   | in        | hfl_pkg::req_t
//  result  | rsp_valid, rsp_ready, rsp_data   | out       | hfl_pkg::rsp_t
//
// every request is accepted in ST_IDLE and finished in ST_EXEC: the accept edge
// launches the read of the free-link ram (next freed handle) and the tag ram; ST_EXEC
// uses that data, writes back and loads the result register.
// a new request is taken while an earlier result still waits in the result register.
// a request stalls in ST_EXEC only while the result register is full and
// not being taken.
// reset clears the allocated flags, the freed stack and the fill counter at once;
// the rams need no clearing pass.
`include "handle_free_list_allocator_assert.svh"

module handle_free_list_allocator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  hfl_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output hfl_pkg::rsp_t rsp_data
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // control state
    state_t                          state_reg, state_next;
    logic [hfl_pkg::TABLE_ENTRIES-1:0] alloc_reg, alloc_next;
    logic [hfl_pkg::IDX_BITS-1:0]    freed_head_reg, freed_head_next;
    logic                            freed_nonempty_reg, freed_nonempty_next;
    logic [hfl_pkg::FILL_BITS-1:0]   fill_count_reg, fill_count_next;
    logic                            rsp_valid_reg, rsp_valid_next;

    // payload registers
    hfl_pkg::req_t                   req_q_reg;
    hfl_pkg::rsp_t                   rsp_reg, rsp_next;

    // ram ports
    logic                            accept;
    logic [hfl_pkg::IDX_BITS-1:0]    link_rdata;
    logic [31:0]                     tag_rdata;
    logic                            link_we;
    logic [hfl_pkg::IDX_BITS-1:0]    link_waddr;
    logic [hfl_pkg::IDX_BITS-1:0]    link_wdata;
    logic                            tag_we;
    logic [hfl_pkg::IDX_BITS-1:0]    tag_waddr;

    // execute-stage decode
    logic                            load;
    logic [hfl_pkg::IDX_BITS-1:0]    q_idx;
    logic                            q_in_range;
    logic                            q_tag_null;
    logic [hfl_pkg::IDX_BITS-1:0]    grant_idx;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // result register is free, or being emptied this cycle
    assign load = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);

    assign q_idx      = hfl_pkg::IDX_BITS'(req_q_reg.handle);
    assign q_in_range = (32'(req_q_reg.handle) < 32'(hfl_pkg::TABLE_ENTRIES));
    assign q_tag_null = ((req_q_reg.object_tag & hfl_pkg::TAG_MASK) == 32'd0);

    // freed stack first, then never-used handles in ascending order
    assign grant_idx = freed_nonempty_reg ? freed_head_reg
                                          : hfl_pkg::IDX_BITS'(fill_count_reg);

    // link of the current freed head, read on accept
    hfl_ram #(
        .WIDTH (hfl_pkg::IDX_BITS),
        .DEPTH (hfl_pkg::TABLE_ENTRIES)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_en   (accept),
        .rd_addr (freed_head_reg),
        .rd_data (link_rdata)
    );

    // object tag of the requested handle, read on accept
    hfl_ram #(
        .WIDTH (32),
        .DEPTH (hfl_pkg::TABLE_ENTRIES)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_we),
        .wr_addr (tag_waddr),
        .wr_data (req_q_reg.object_tag & hfl_pkg::TAG_MASK),
        .rd_en   (accept),
        .rd_addr (hfl_pkg::IDX_BITS'(req_data.handle)),
        .rd_data (tag_rdata)
    );

    always_comb
    begin
        state_next          = state_reg;
        alloc_next          = alloc_reg;
        freed_head_next     = freed_head_reg;
        freed_nonempty_next = freed_nonempty_reg;
        fill_count_next     = fill_count_reg;
        rsp_valid_next      = rsp_valid_reg;
        rsp_next            = rsp_reg;
        link_we             = 1'b0;
        link_waddr          = q_idx;
        link_wdata          = freed_nonempty_reg ? freed_head_reg : q_idx;
        tag_we              = 1'b0;
        tag_waddr           = grant_idx;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (load)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_next.result_handle = req_q_reg.handle;
                    rsp_next.result_tag    = 32'd0;
                    rsp_next.status        = hfl_pkg::STATUS_OK;

                    if (req_q_reg.kind == hfl_pkg::KIND_ALLOC)
                    begin
                        rsp_next.result_handle = 8'd0;
                        if (q_tag_null)
                        begin
                            rsp_next.status = hfl_pkg::STATUS_NULL;
                        end
                        else if (!freed_nonempty_reg &&
                                 fill_count_reg ==
                                 hfl_pkg::FILL_BITS'(hfl_pkg::TABLE_ENTRIES))
                        begin
                            rsp_next.status = hfl_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            rsp_next.result_handle = 8'(grant_idx);
                            alloc_next[grant_idx]  = 1'b1;
                            tag_we                 = 1'b1;
                            if (freed_nonempty_reg)
                            begin
                                // bottom of the stack links to itself
                                if (link_rdata == freed_head_reg)
                                begin
                                    freed_nonempty_next = 1'b0;
                                end
                                else
                                begin
                                    freed_head_next = link_rdata;
                                end
                            end
                            else
                            begin
                                fill_count_next = fill_count_reg + 1'b1;
                            end
                        end
                    end
                    else if (!q_in_range)
                    begin
                        rsp_next.status = hfl_pkg::STATUS_RANGE;
                    end
                    else if (!alloc_reg[q_idx])
                    begin
                        // double free or stale look-up
                        rsp_next.status = hfl_pkg::STATUS_UNALLOC;
                    end
                    else
                    begin
                        rsp_next.result_tag = tag_rdata;
                        if (req_q_reg.kind == hfl_pkg::KIND_FREE)
                        begin
                            alloc_next[q_idx]   = 1'b0;
                            link_we             = 1'b1;
                            freed_head_next     = q_idx;
                            freed_nonempty_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            alloc_reg          <= '0;
            freed_head_reg     <= '0;
            freed_nonempty_reg <= 1'b0;
            fill_count_reg     <= '0;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            alloc_reg          <= alloc_next;
            freed_head_reg     <= freed_head_next;
            freed_nonempty_reg <= freed_nonempty_next;
            fill_count_reg     <= fill_count_next;
            rsp_valid_reg      <= rsp_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_q_reg <= req_data;
        end
        rsp_reg <= rsp_next;
    end

    `HFL_ASSERT_NOW(a_fill_bound, 1'b1,
        fill_count_reg <= hfl_pkg::FILL_BITS'(hfl_pkg::TABLE_ENTRIES))
    `HFL_ASSERT_NEXT(a_alloc_marks,
        load && tag_we,
        alloc_reg[$past(grant_idx)])
    `HFL_ASSERT_NEXT(a_free_pushes,
        load && link_we,
        freed_nonempty_reg && freed_head_reg == $past(q_idx) && !alloc_reg[$past(q_idx)])
    `HFL_ASSERT_NOW(a_one_ram_writer,
        tag_we || link_we,
        load && !(tag_we && link_we))

endmodule
